// ----- hw/rtl/pin_control_interrupt_port_defines.svh -----
// Assertion macros used by the checker file of this block.
`ifndef PIN_CONTROL_INTERRUPT_PORT_DEFINES_SVH
`define PIN_CONTROL_INTERRUPT_PORT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PCIP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pcip: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define PCIP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pcip: next-cycle check failed");

`endif

// ----- hw/rtl/pcip_pkg.sv -----
`default_nettype none
package pcip_pkg;

  // Implemented bits of a pin control word; the flag sits in bit 24.
  localparam logic [31:0] STORE_MASK = 32'h000F0757;
  localparam logic [15:0] LOW_MASK   = 16'h0757;
  localparam int unsigned FLAG_POS   = 24;
  localparam int unsigned TRIG_LSB   = 16;
  localparam int unsigned MUX_LSB    = 8;

  // Trigger field codes.
  localparam logic [3:0] TRIG_LEVEL_LOW  = 4'h8;
  localparam logic [3:0] TRIG_RISING     = 4'h9;
  localparam logic [3:0] TRIG_FALLING    = 4'hA;
  localparam logic [3:0] TRIG_EITHER     = 4'hB;
  localparam logic [3:0] TRIG_LEVEL_HIGH = 4'hC;

  // NMI source: pin 5 in mux mode 3.
  localparam int unsigned NMI_PIN = 5;
  localparam logic [2:0]  MUX_NMI = 3'd3;

  // Word offsets.
  localparam logic [9:0] REG_GLOBAL_LOW  = 10'd32;
  localparam logic [9:0] REG_GLOBAL_HIGH = 10'd33;
  localparam logic [9:0] REG_STATUS      = 10'd40;

  localparam logic [31:0] BAD_READ = 32'hDEADBEEF;

  typedef struct packed {
    logic ctl_wr;
    logic ctl_rd;
    logic glob_lo_wr;
    logic glob_hi_wr;
    logic stat_wr;
    logic stat_rd;
    logic unmapped;
    logic chk;
  } access_t;

  // Bit i set when pin base+i exists.
  function automatic logic [15:0] half_sel_mask(input int unsigned base,
                                                input int unsigned count);
    logic [15:0] m;
    m = '0;
    for (int unsigned i = 0; i < 16; i++) begin
      m[i] = ((base + i) < count);
    end
    return m;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/pin_control_interrupt_port.sv -----
// Pin control and interrupt port.
// Input channel (in_valid/in_ready) carries one bus access per item:
// req_type, reg_index, wr_word and the current pin_levels. Output channel
// (out_valid/out_ready) returns exactly one result item per access:
// read_data, bad_offset, irq_line (any pin flag set) and nmi_line.
// cfg_we/cfg_wdata set nmi_port_select (port B NMI detection on pin 5).
// The input register holds each accepted item and the result register takes it
// from there when the output is free. Throughput: one item per cycle while the
// receiver keeps up; the pin cells update all PIN_COUNT control words in parallel
// in the single stage between the input and result registers. When the receiver
// stalls, the result register holds its item and the input register the next one;
// in_ready drops only when both are full and the result is not taken, or in reset.
// Reset (synchronous, active high) clears all pin control words, the previous
// pin levels, the NMI request, nmi_port_select and both valid flags.
`default_nettype none
module pin_control_interrupt_port #(
  parameter int unsigned PIN_COUNT = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [9:0]  reg_index,
  input  logic [31:0] wr_word,
  input  logic [31:0] pin_levels,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] read_data,
  output logic        bad_offset,
  output logic        irq_line,
  output logic        nmi_line
);

  localparam int unsigned IdxW = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;

  // Input register stage.
  logic              stage_valid;
  pcip_pkg::access_t stage_acc;
  logic [9:0]        stage_idx;
  logic [31:0]       stage_data;
  logic [31:0]       stage_levels;
  logic              stage_rd;

  pcip_pkg::access_t in_acc;

  // Block state.
  logic        nmi_port_select;
  logic [31:0] prev_levels;
  logic        nmi_pending;
  logic        nmi_pending_next;

  logic [31:0] word_q  [PIN_COUNT];
  logic [31:0] word_nx [PIN_COUNT];
  logic [31:0] status_next;
  logic [2:0]  nmi_mux;
  logic [31:0] rd_value;
  logic        step;
  logic        in_fire;

  // Advance the stage whenever the result register is free or being taken.
  assign step     = stage_valid & (~out_valid | out_ready);
  assign in_ready = ~rst & (~stage_valid | step);
  assign in_fire  = in_valid & in_ready;

  pcip_decode #(
    .PIN_COUNT (PIN_COUNT)
  ) u_decode (
    .req_type  (req_type),
    .reg_index (reg_index),
    .sel_bits  (wr_word[31:16]),
    .acc       (in_acc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_fire) begin
      stage_valid <= 1'b1;
    end else if (step) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stage_acc    <= in_acc;
      stage_idx    <= reg_index;
      stage_data   <= wr_word;
      stage_levels <= pin_levels;
    end
  end

  // One cell per pin: control word register plus its access and trigger logic.
  for (genvar p = 0; p < PIN_COUNT; p++) begin : g_pin
    pcip_pin_cell #(
      .PIN_INDEX (p)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .step       (step),
      .acc        (stage_acc),
      .idx        (stage_idx),
      .wr_word    (stage_data),
      .level      (stage_levels[p]),
      .prev_level (prev_levels[p]),
      .word       (word_q[p]),
      .word_next  (word_nx[p])
    );
  end

  // Gather the flags after the access; missing pins report nothing.
  for (genvar p = 0; p < 32; p++) begin : g_status
    if (p < PIN_COUNT) begin : g_have
      assign status_next[p] = word_nx[p][pcip_pkg::FLAG_POS];
    end else begin : g_none
      assign status_next[p] = 1'b0;
    end
  end

  if (PIN_COUNT > pcip_pkg::NMI_PIN) begin : g_nmi_word
    assign nmi_mux = word_nx[pcip_pkg::NMI_PIN][pcip_pkg::MUX_LSB +: 3];
  end else begin : g_nmi_none
    assign nmi_mux = 3'd0;
  end

  // Refresh the NMI request on each pin check when this port is port B.
  always_comb begin
    nmi_pending_next = nmi_pending;
    if (stage_acc.chk && nmi_port_select) begin
      nmi_pending_next = (nmi_mux == pcip_pkg::MUX_NMI)
                       & ~stage_levels[pcip_pkg::NMI_PIN];
    end
  end

  // Pick the read value for the access.
  always_comb begin
    rd_value = '0;
    if (stage_acc.ctl_rd) begin
      rd_value = word_q[stage_idx[IdxW-1:0]];
    end else if (stage_acc.stat_rd) begin
      rd_value = status_next;
    end else if (stage_acc.unmapped && stage_rd) begin
      rd_value = pcip_pkg::BAD_READ;
    end
  end

  // Unmapped accesses carry no write decode, so the read/write sense is kept
  // from the request type captured with the item.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      stage_rd <= ~req_type;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nmi_port_select <= 1'b0;
    end else if (cfg_we) begin
      nmi_port_select <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_levels <= '0;
      nmi_pending <= 1'b0;
    end else if (step) begin
      if (stage_acc.chk) begin
        prev_levels <= stage_levels;
      end
      nmi_pending <= nmi_pending_next;
    end
  end

  // Result register: load on step, drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      read_data  <= rd_value;
      bad_offset <= stage_acc.unmapped;
      irq_line   <= |status_next;
      nmi_line   <= nmi_pending_next;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/pcip_decode.sv -----
`default_nettype none
module pcip_decode #(
  parameter int unsigned PIN_COUNT = 32
) (
  input  logic              req_type,
  input  logic [9:0]        reg_index,
  input  logic [15:0]       sel_bits,
  output pcip_pkg::access_t acc
);

  localparam logic [9:0]  PinLimit = 10'(PIN_COUNT);
  localparam logic [15:0] LoMask   = pcip_pkg::half_sel_mask(0, PIN_COUNT);
  localparam logic [15:0] HiMask   = pcip_pkg::half_sel_mask(16, PIN_COUNT);

  logic is_pin;
  logic is_lo;
  logic is_hi;
  logic is_stat;

  always_comb begin
    is_pin  = (reg_index < PinLimit);
    is_lo   = (reg_index == pcip_pkg::REG_GLOBAL_LOW);
    is_hi   = (reg_index == pcip_pkg::REG_GLOBAL_HIGH);
    is_stat = (reg_index == pcip_pkg::REG_STATUS);

    acc.ctl_wr     = is_pin & req_type;
    acc.ctl_rd     = is_pin & ~req_type;
    acc.glob_lo_wr = is_lo & req_type;
    acc.glob_hi_wr = is_hi & req_type;
    acc.stat_wr    = is_stat & req_type;
    acc.stat_rd    = is_stat & ~req_type;
    acc.unmapped   = ~(is_pin | is_lo | is_hi | is_stat);
    // Pin check runs after control writes and status accesses, and after a global
    // write that hits at least one existing pin.
    acc.chk = acc.ctl_wr | acc.stat_wr | acc.stat_rd
            | (acc.glob_lo_wr & (|(sel_bits & LoMask)))
            | (acc.glob_hi_wr & (|(sel_bits & HiMask)));
  end

endmodule
`default_nettype wire

// ----- hw/rtl/pcip_pin_cell.sv -----
`default_nettype none
module pcip_pin_cell #(
  parameter int unsigned PIN_INDEX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  pcip_pkg::access_t acc,
  input  logic [9:0]        idx,
  input  logic [31:0]       wr_word,
  input  logic              level,
  input  logic              prev_level,
  output logic [31:0]       word,
  output logic [31:0]       word_next
);

  localparam logic [9:0]  MyIdx  = 10'(PIN_INDEX);
  localparam int unsigned SelPos = 16 + (PIN_INDEX % 16);
  localparam bit          InHigh = (PIN_INDEX >= 16);

  logic [31:0] mid;
  logic        glob_sel;
  logic        rise;
  logic        fall;
  logic        hit;

  always_comb begin
    glob_sel = wr_word[SelPos] & (InHigh ? acc.glob_hi_wr : acc.glob_lo_wr);
    rise     = level & ~prev_level;
    fall     = ~level & prev_level;

    mid = word;
    if (acc.ctl_wr && (idx == MyIdx)) begin
      // Flag is write-one-to-clear; every other bit takes the masked data.
      mid = wr_word & pcip_pkg::STORE_MASK;
      mid[pcip_pkg::FLAG_POS] = word[pcip_pkg::FLAG_POS] & ~wr_word[pcip_pkg::FLAG_POS];
    end
    if (glob_sel) begin
      mid[15:0] = wr_word[15:0] & pcip_pkg::LOW_MASK;
    end
    if (acc.stat_wr && wr_word[PIN_INDEX]) begin
      mid[pcip_pkg::FLAG_POS] = 1'b0;
    end

    case (mid[pcip_pkg::TRIG_LSB +: 4])
      pcip_pkg::TRIG_LEVEL_LOW:  hit = ~level;
      pcip_pkg::TRIG_RISING:     hit = rise;
      pcip_pkg::TRIG_FALLING:    hit = fall;
      pcip_pkg::TRIG_EITHER:     hit = rise | fall;
      pcip_pkg::TRIG_LEVEL_HIGH: hit = level;
      default:                   hit = 1'b0;
    endcase

    word_next = mid;
    if (acc.chk && hit) begin
      word_next[pcip_pkg::FLAG_POS] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word <= '0;
    end else if (step) begin
      word <= word_next;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/pcip_checker.sv -----
`default_nettype none
`include "pin_control_interrupt_port_defines.svh"
module pcip_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] read_data,
  input wire logic        bad_offset
);

  // A stalled result holds its payload.
  `PCIP_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(read_data))

  // Unmapped accesses read back the error pattern or zero for writes.
  `PCIP_ASSERT_NOW(a_bad_data, clk, rst, out_valid && bad_offset, read_data == 32'hDEADBEEF || read_data == 32'h0)

  // A result appearing on an empty output comes from an item accepted into the input register and moved straight on.
  `PCIP_ASSERT_NOW(a_rise, clk, rst, out_valid && !$past(out_valid), $past(in_valid && in_ready, 2))

endmodule

bind pin_control_interrupt_port pcip_checker u_pcip_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .read_data  (read_data),
  .bad_offset (bad_offset)
);
`default_nettype wire

// ----- tb/pin_control_interrupt_port_test.sv -----
`timescale 1ns / 100ps

module pin_control_interrupt_port_test;

  localparam int unsigned PINS = 32;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned ITEMS_PER_PHASE = 440;

  // Access direction carried in req_type.
  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // Offsets outside every mapped word, used by the directed part, and the NMI pin's word.
  localparam logic [9:0] OFS_HOLE_LOW  = 10'd34;
  localparam logic [9:0] OFS_HOLE_MID  = 10'd41;
  localparam logic [9:0] OFS_HOLE_LAST = 10'd1023;
  localparam logic [9:0] OFS_NMI_PIN   = 10'(pcip_pkg::NMI_PIN);

  // One result item as the block presents it.
  typedef struct packed {
    logic [31:0] rd;
    logic        bad;
    logic        irq;
    logic        nmi;
  } port_reply_t;

  // Mirror of the pin port: control words, last sampled levels, held NMI request
  // and the port B select, plus the replies that accepted accesses still owe.
  class pin_port_scoreboard;
    logic [31:0] ctl_word [PINS];
    logic [31:0] last_levels;
    logic        nmi_held;
    logic        port_b;
    port_reply_t replies_due [$];
    int unsigned mismatches;

    function new();
      for (int p = 0; p < PINS; p++) ctl_word[p] = '0;
      last_levels = '0;
      nmi_held = 1'b0;
      port_b = 1'b0;
      mismatches = 0;
    endfunction

    function void set_port_select(logic sel);
      port_b = sel;
    endfunction

    function int unsigned outstanding();
      return replies_due.size();
    endfunction

    // Sample the pins: latch flags per trigger field, then refresh the NMI request on port B.
    function void scan_pins(logic [31:0] levels);
      logic [31:0] rise;
      logic [31:0] fall;
      logic [3:0]  trig;
      logic        hit;
      rise = ~last_levels & levels;
      fall = last_levels & ~levels;
      for (int p = 0; p < PINS; p++) begin
        trig = ctl_word[p][pcip_pkg::TRIG_LSB +: 4];
        case (trig)
          pcip_pkg::TRIG_LEVEL_LOW:  hit = !levels[p];
          pcip_pkg::TRIG_RISING:     hit = rise[p];
          pcip_pkg::TRIG_FALLING:    hit = fall[p];
          pcip_pkg::TRIG_EITHER:     hit = rise[p] | fall[p];
          pcip_pkg::TRIG_LEVEL_HIGH: hit = levels[p];
          default:                   hit = 1'b0;
        endcase
        if (hit) ctl_word[p][pcip_pkg::FLAG_POS] = 1'b1;
      end
      last_levels = levels;
      if (port_b)
        nmi_held = (ctl_word[pcip_pkg::NMI_PIN][pcip_pkg::MUX_LSB +: 3] == pcip_pkg::MUX_NMI)
                   && !levels[pcip_pkg::NMI_PIN];
    endfunction

    function logic [31:0] flag_word();
      logic [31:0] s;
      s = '0;
      for (int p = 0; p < PINS; p++) s[p] = ctl_word[p][pcip_pkg::FLAG_POS];
      return s;
    endfunction

    // Apply one accepted access to the mirror and queue the reply it causes.
    function void note_access(logic req, logic [9:0] idx, logic [31:0] data,
                              logic [31:0] levels);
      port_reply_t r;
      logic        keep;
      logic [15:0] sel;
      int unsigned base;
      logic        any;
      r = '0;
      if (idx < PINS) begin
        if (req == REQ_WRITE) begin
          keep = ctl_word[idx[4:0]][pcip_pkg::FLAG_POS] & ~data[pcip_pkg::FLAG_POS];
          ctl_word[idx[4:0]] = data & pcip_pkg::STORE_MASK;
          ctl_word[idx[4:0]][pcip_pkg::FLAG_POS] = keep;
          scan_pins(levels);
        end else begin
          r.rd = ctl_word[idx[4:0]];
        end
      end else if (idx == pcip_pkg::REG_GLOBAL_LOW || idx == pcip_pkg::REG_GLOBAL_HIGH) begin
        if (req == REQ_WRITE) begin
          sel = data[31:16];
          base = (idx == pcip_pkg::REG_GLOBAL_HIGH) ? 16 : 0;
          any = 1'b0;
          for (int i = 0; i < 16; i++) begin
            if (sel[i] && (base + i) < PINS) begin
              ctl_word[base + i][15:0] = data[15:0] & pcip_pkg::LOW_MASK;
              any = 1'b1;
            end
          end
          if (any) scan_pins(levels);
        end
      end else if (idx == pcip_pkg::REG_STATUS) begin
        if (req == REQ_WRITE) begin
          for (int p = 0; p < PINS; p++)
            if (data[p]) ctl_word[p][pcip_pkg::FLAG_POS] = 1'b0;
          scan_pins(levels);
        end else begin
          scan_pins(levels);
          r.rd = flag_word();
        end
      end else begin
        r.bad = 1'b1;
        if (req == REQ_READ) r.rd = pcip_pkg::BAD_READ;
      end
      r.irq = |flag_word();
      r.nmi = nmi_held;
      replies_due.push_back(r);
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s differs, expected %h actual %h", $time, field, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(port_reply_t seen);
      port_reply_t want;
      if (replies_due.size() == 0) begin
        $display("%0t: result with nothing outstanding, expected none actual %h",
                 $time, seen);
        mismatches++;
      end else begin
        want = replies_due.pop_front();
        compare("read_data", want.rd, seen.rd);
        compare("bad_offset", 32'(want.bad), 32'(seen.bad));
        compare("irq_line", 32'(want.irq), 32'(seen.irq));
        compare("nmi_line", 32'(want.nmi), 32'(seen.nmi));
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic        req_type;
  logic [9:0]  reg_index;
  logic [31:0] wr_word;
  logic [31:0] pin_levels;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] read_data;
  logic        bad_offset;
  logic        irq_line;
  logic        nmi_line;

  pin_port_scoreboard sb;
  bit          steady = 1'b0;   // set: no random idle gaps on either side
  int unsigned cycle_count = 0;

  pin_control_interrupt_port #(.PIN_COUNT(PINS)) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .reg_index  (reg_index),
    .wr_word    (wr_word),
    .pin_levels (pin_levels),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .read_data  (read_data),
    .bad_offset (bad_offset),
    .irq_line   (irq_line),
    .nmi_line   (nmi_line)
  );

  // 8 ns clock: low half then high half.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Watchdog: end the run if it never drains.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offer one item. Enter and leave on a falling edge; drop valid only when
  // an idle gap is drawn, so a back-to-back item keeps valid high untouched.
  task automatic send_access(input logic req, input logic [9:0] idx,
                             input logic [31:0] data, input logic [31:0] lv);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= req;
    reg_index  <= idx;
    wr_word    <= data;
    pin_levels <= lv;
    // Hold the payload until the block takes it.
    do @(posedge clk); while (!in_ready);
    sb.note_access(req, idx, data, lv);
    @(negedge clk);
  endtask

  // Write the port B select while the block is idle: drain, pause, write.
  task automatic set_port_b(input logic sel);
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (3) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= sel;
    sb.set_port_select(sel);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Draw one random access: trigger setups, control and global accesses, status
  // traffic and noise; levels mostly toggle a few pins so edges stay sparse.
  function automatic void pick_access(output logic req, output logic [9:0] idx,
                                      output logic [31:0] data,
                                      inout logic [31:0] lv);
    int unsigned kind;
    kind = $urandom_range(0, 99);
    data = $urandom;
    req  = REQ_WRITE;
    if ($urandom_range(0, 3) == 0) lv = $urandom;
    else lv = lv ^ ($urandom & $urandom & $urandom);
    if (kind < 30) begin
      // Control write: mostly a live trigger code, often the NMI mux on pin 5.
      idx = 10'($urandom_range(0, PINS - 1));
      if ($urandom_range(0, 4) == 0) idx = OFS_NMI_PIN;
      if ($urandom_range(0, 5) != 0) data[19:16] = 4'($urandom_range(8, 12));
      if ($urandom_range(0, 2) == 0) data[10:8] = pcip_pkg::MUX_NMI;
      data[pcip_pkg::FLAG_POS] = ($urandom_range(0, 3) == 0);
    end else if (kind < 40) begin
      idx = 10'($urandom_range(0, PINS - 1));
      req = REQ_READ;
    end else if (kind < 50) begin
      idx = $urandom_range(0, 1) ? pcip_pkg::REG_GLOBAL_HIGH : pcip_pkg::REG_GLOBAL_LOW;
      if ($urandom_range(0, 9) == 0) req = REQ_READ;
      if ($urandom_range(0, 7) == 0) data[31:16] = '0;
    end else if (kind < 75) begin
      idx = pcip_pkg::REG_STATUS;
      req = REQ_READ;
    end else if (kind < 88) begin
      idx = pcip_pkg::REG_STATUS;
    end else begin
      // Noise: anything outside the mapped words, either direction.
      do idx = 10'($urandom_range(pcip_pkg::REG_GLOBAL_HIGH + 1, 1023));
      while (idx == pcip_pkg::REG_STATUS);
      req = 1'($urandom_range(0, 1));
    end
  endfunction

  // Receiver: idle a random gap before each item unless steady, and hold off twice for a long
  // stretch so the block fills up and drops in_ready.
  initial begin : result_side
    int unsigned hold;
    int unsigned taken;
    port_reply_t seen;
    taken = 0;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (taken == 400 || taken == 1300) hold = 90;
      else if (steady) hold = 0;
      else hold = $urandom_range(0, 4);
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      seen.rd  = read_data;
      seen.bad = bad_offset;
      seen.irq = irq_line;
      seen.nmi = nmi_line;
      sb.check_result(seen);
      taken++;
      @(negedge clk);
    end
  end

  initial begin : access_side
    logic        req;
    logic [9:0]  idx;
    logic [31:0] data;
    logic [31:0] lv;
    sb = new();
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_wdata  = 1'b0;
    in_valid   = 1'b0;
    req_type   = REQ_READ;
    reg_index  = '0;
    wr_word    = '0;
    pin_levels = '0;
    lv         = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part runs as port B so the NMI path is live.
    set_port_b(1'b1);
    send_access(REQ_READ,  10'd0,  32'h0, 32'h0);                 // reset word
    send_access(REQ_WRITE, 10'd31, 32'hFFFF_FFFF, 32'h0);         // mask all ones
    send_access(REQ_READ,  10'd31, 32'h0, 32'h0);
    send_access(REQ_WRITE, 10'd3,  32'h0008_0000, 32'h0);         // level low sets
    send_access(REQ_WRITE, 10'd3,  32'h0008_0000, 32'hFFFF_FFFF); // flag kept
    send_access(REQ_WRITE, 10'd3,  32'h0100_0000, 32'hFFFF_FFFF); // write-one clears
    send_access(REQ_WRITE, 10'd4,  32'h0009_0000, 32'h0);         // rising edge
    send_access(REQ_READ,  pcip_pkg::REG_STATUS, 32'h0, 32'h0000_0010);
    send_access(REQ_WRITE, 10'd6,  32'h000A_0000, 32'h0000_0040); // falling edge
    send_access(REQ_READ,  pcip_pkg::REG_STATUS, 32'h0, 32'h0);
    send_access(REQ_WRITE, 10'd7,  32'h000B_0000, 32'h0);         // either edge
    send_access(REQ_READ,  pcip_pkg::REG_STATUS, 32'h0, 32'h0000_0080);
    send_access(REQ_WRITE, 10'd8,  32'h000C_0000, 32'h0000_0100); // level high
    send_access(REQ_WRITE, 10'd9,  32'h000D_0000, 32'h0000_0200); // dead code
    send_access(REQ_WRITE, pcip_pkg::REG_STATUS, 32'hFFFF_FFFF, 32'h0);
    send_access(REQ_WRITE, pcip_pkg::REG_GLOBAL_LOW,  32'hFFFF_FFFF, 32'h0);
    send_access(REQ_WRITE, pcip_pkg::REG_GLOBAL_HIGH, 32'h0001_0300, 32'h0);
    send_access(REQ_WRITE, pcip_pkg::REG_GLOBAL_LOW,  32'h0000_FFFF, 32'h0000_0020); // no pins
    send_access(REQ_READ,  pcip_pkg::REG_GLOBAL_LOW,  32'h0, 32'h0);
    send_access(REQ_READ,  pcip_pkg::REG_GLOBAL_HIGH, 32'h0, 32'h0);
    send_access(REQ_WRITE, OFS_NMI_PIN, 32'h0000_0300, 32'h0);    // NMI raised
    send_access(REQ_READ,  pcip_pkg::REG_STATUS, 32'h0, 32'h0000_0020); // NMI dropped
    send_access(REQ_WRITE, OFS_NMI_PIN, 32'h0000_0300, 32'h0);
    send_access(REQ_READ,  OFS_HOLE_MID,  32'h0, 32'h0);
    send_access(REQ_WRITE, OFS_HOLE_LAST, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_access(REQ_READ,  OFS_HOLE_LOW,  32'h0, 32'h0);

    // Random phases: alternate the port select; the third phase draws no random idle gaps.
    for (int ph = 0; ph < 4; ph++) begin
      set_port_b(ph[0]);
      steady = (ph == 2);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick_access(req, idx, data, lv);
        send_access(req, idx, data, lv);
      end
    end
    in_valid <= 1'b0;

    // Drain, then give the pipeline time to show any stray result.
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
